>>> src/rgbbox_pkg.sv
// Shared types and constants for the RGB 3x3 weighted box filter.
// No dependencies; used by every module of the block.
package rgbbox_pkg;

  // Pixel layout: three 8-bit channels, red in the top byte
  localparam int unsigned NCH    = 3;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned CH_RED = 2;
  localparam int unsigned CH_GRN = 1;
  localparam int unsigned CH_BLU = 0;

  // Sum of ten 8-bit terms (centre counted twice)
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned SUM_MAX = 2550;

  // Configuration registers
  localparam int unsigned WREG_W     = 12;
  localparam int unsigned HREG_W     = 13;
  localparam int unsigned WIDTH_RST  = 640;
  localparam int unsigned HEIGHT_RST = 480;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // Stream position and result counting
  localparam int unsigned ROW_W     = 13;
  localparam int unsigned ROW_LIMIT = 8191;
  localparam int unsigned CNT_W     = 23;
  localparam int unsigned PROD_W    = WREG_W + HREG_W;

  // Default line store depth
  localparam int unsigned MAX_WIDTH_DEF = 2048;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [NCH-1:0][CH_W-1:0] pix_t;

  // One window column: top, middle and bottom row of the neighbourhood
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Window control from the datapath
  typedef struct packed {
    logic shift;      // an item passes through the window
    logic col_start;  // item opens a row: right edge of the old row is zero
    logic clear;      // stream restart
  } win_ctrl_t;

  typedef logic [NCH-1:0][SUM_W-1:0] sums_t;

endpackage

>>> src/rgbbox_line_buf.sv
// One line store: single write port, single read port with registered read data.
// Depends on rgbbox_pkg for the pixel type.
module rgbbox_line_buf #(
  parameter int unsigned DEPTH = rgbbox_pkg::MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  rgbbox_pkg::pix_t  wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output rgbbox_pkg::pix_t  rdata_o
);

  rgbbox_pkg::pix_t mem [DEPTH];
  rgbbox_pkg::pix_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rgbbox_window.sv
// 3x3 window over the pixel stream and the weighted per-channel sums.
// Depends on rgbbox_pkg for column, control and sum types.
module rgbbox_window (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbbox_pkg::win_ctrl_t ctrl_i,
  input  rgbbox_pkg::col_t      col_i,
  output rgbbox_pkg::sums_t     sums_o
);

  // Only the two older columns are kept; the newest comes in on col_i
  rgbbox_pkg::col_t left_q, centre_q;
  rgbbox_pkg::col_t right;

  // a row start sees a zero right edge
  assign right = ctrl_i.col_start ? '0 : col_i;

  // weight 1 on the neighbours, 2 on the centre
  always_comb begin
    for (int ch = 0; ch < rgbbox_pkg::NCH; ch++) begin
      sums_o[ch] = rgbbox_pkg::SUM_W'(left_q.top[ch])
                 + rgbbox_pkg::SUM_W'(left_q.mid[ch])
                 + rgbbox_pkg::SUM_W'(left_q.bot[ch])
                 + rgbbox_pkg::SUM_W'(centre_q.top[ch])
                 + (rgbbox_pkg::SUM_W'(centre_q.mid[ch]) << 1)
                 + rgbbox_pkg::SUM_W'(centre_q.bot[ch])
                 + rgbbox_pkg::SUM_W'(right.top[ch])
                 + rgbbox_pkg::SUM_W'(right.mid[ch])
                 + rgbbox_pkg::SUM_W'(right.bot[ch]);
    end
  end

  // shift; at a row start the window restarts with the new column only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      centre_q <= '0;
    end else if (ctrl_i.clear) begin
      left_q   <= '0;
      centre_q <= '0;
    end else if (ctrl_i.shift) begin
      left_q   <= ctrl_i.col_start ? '0 : centre_q;
      centre_q <= col_i;
    end
  end

endmodule

>>> src/rgb_3x3_weighted_box_filter.sv
// Top level of the RGB 3x3 weighted box filter.
// Depends on rgbbox_pkg, rgbbox_line_buf and rgbbox_window.
//
// Usage:
//   Pixels enter in raster order on the in_* channel (valid/ready), one item
//   per image position; func_i = 1 marks a flush item that stands for a
//   padding position. Each image pixel gives one result on the out_* channel:
//   per channel, the 3x3 neighbourhood sum with weight 2 on the centre and
//   weight 1 on the eight neighbours, zero outside the image. last_pixel_o
//   marks the final result of an image, after which the position restarts.
//   The first W + 1 items of an image give no result, so W + 1 flush items
//   after the last pixel drain the tail.
//   Throughput: one item per cycle while results are taken. The accepting
//   edge registers the item together with its line store read; the window
//   and adder tree fill the output register when that item moves on.
//   The output register decouples the sides: a stalled receiver only holds
//   the input when a result is waiting and the next item also gives one.
//   Reset: size registers go to 640 x 480, position and window clear; line
//   stores are not cleared (entries are masked until written in this image).
//   Writes to image_width (0x0) or image_height (0x4) restart the stream and
//   are meant for idle periods.
module rgb_3x3_weighted_box_filter #(
  parameter int unsigned MAX_WIDTH = rgbbox_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rgbbox_pkg::PADDR_W-1:0]     paddr,
  input  logic [rgbbox_pkg::PDATA_W-1:0]     pwdata,
  output logic [rgbbox_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic [rgbbox_pkg::CH_W-1:0]        red_i,
  input  logic [rgbbox_pkg::CH_W-1:0]        green_i,
  input  logic [rgbbox_pkg::CH_W-1:0]        blue_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rgbbox_pkg::SUM_W-1:0]       red_sum_o,
  output logic [rgbbox_pkg::SUM_W-1:0]       green_sum_o,
  output logic [rgbbox_pkg::SUM_W-1:0]       blue_sum_o,
  output logic                               last_pixel_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  // item state between the input and the window stage
  typedef struct packed {
    logic [AW-1:0]    addr;
    rgbbox_pkg::pix_t pix;
    logic             top_ok;
    logic             mid_ok;
    logic             col_start;
    logic             emit;
    logic             last;
    logic             byp;
  } stage_t;

  logic [rgbbox_pkg::WREG_W-1:0] width_q, w_eff;
  logic [rgbbox_pkg::HREG_W-1:0] height_q, h_eff;
  logic [rgbbox_pkg::PROD_W-1:0] img_size;
  logic                          cfg_wr;
  rgbbox_pkg::cfg_reg_e          cfg_sel;

  logic [AW-1:0]                 col_q, col_d;
  logic [rgbbox_pkg::ROW_W-1:0]  row_q, row_d;
  logic [rgbbox_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic                          col_wrap;

  logic                          in_acc, s1_adv;
  logic                          s1_valid_q;
  stage_t                        s1_q, s1_d;

  rgbbox_pkg::pix_t              up_rd, mid_rd, up_raw, mid_raw;
  rgbbox_pkg::pix_t              byp_up_q, byp_mid_q;
  rgbbox_pkg::col_t              new_col;
  rgbbox_pkg::win_ctrl_t         win_ctrl;
  rgbbox_pkg::sums_t             sums;

  logic                          res_valid_q;
  rgbbox_pkg::sums_t             res_sums_q;
  logic                          res_last_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = rgbbox_pkg::cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rgbbox_pkg::WREG_W'(rgbbox_pkg::WIDTH_RST);
      height_q <= rgbbox_pkg::HREG_W'(rgbbox_pkg::HEIGHT_RST);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        rgbbox_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[rgbbox_pkg::WREG_W-1:0];
        rgbbox_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[rgbbox_pkg::HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      rgbbox_pkg::REG_IMAGE_WIDTH:  prdata = rgbbox_pkg::PDATA_W'(width_q);
      rgbbox_pkg::REG_IMAGE_HEIGHT: prdata = rgbbox_pkg::PDATA_W'(height_q);
      default:                      prdata = '0;
    endcase
  end

  // effective image size, clamped to 1..max
  always_comb begin
    if (width_q == '0) begin
      w_eff = rgbbox_pkg::WREG_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = rgbbox_pkg::WREG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = rgbbox_pkg::HREG_W'(1);
    end else if (32'(height_q) > 32'(rgbbox_pkg::MAX_HEIGHT)) begin
      h_eff = rgbbox_pkg::HREG_W'(rgbbox_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // pixels per image; static between configuration writes
  assign img_size = rgbbox_pkg::PROD_W'(w_eff) * rgbbox_pkg::PROD_W'(h_eff);

  // ---------------------------------------------------------------------------
  // Handshake
  assign s1_adv     = s1_valid_q & (~s1_q.emit | ~res_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_acc     = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------------------
  // Position of the incoming item and what it will do
  assign col_wrap = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign cnt_inc  = cnt_q + rgbbox_pkg::CNT_W'(1);

  always_comb begin
    s1_d.addr      = col_q;
    s1_d.pix       = '0;
    if (!func_i && (row_q < h_eff)) begin
      s1_d.pix[rgbbox_pkg::CH_RED] = red_i;
      s1_d.pix[rgbbox_pkg::CH_GRN] = green_i;
      s1_d.pix[rgbbox_pkg::CH_BLU] = blue_i;
    end
    s1_d.top_ok    = (row_q >= rgbbox_pkg::ROW_W'(2))
                   && ((row_q - rgbbox_pkg::ROW_W'(2)) < h_eff);
    s1_d.mid_ok    = (row_q >= rgbbox_pkg::ROW_W'(1))
                   && ((row_q - rgbbox_pkg::ROW_W'(1)) < h_eff);
    s1_d.col_start = (col_q == '0);
    s1_d.emit      = (row_q >= rgbbox_pkg::ROW_W'(2))
                   || ((row_q == rgbbox_pkg::ROW_W'(1)) && (col_q != '0));
    s1_d.last      = s1_d.emit && (32'(cnt_inc) == 32'(img_size));
    // same line store entry as the item now leaving: take its data directly
    s1_d.byp       = s1_adv && (s1_q.addr == col_q);

    // next position; a finished image restarts the stream
    col_d = col_wrap ? '0 : col_q + AW'(1);
    row_d = row_q;
    if (col_wrap && (row_q != rgbbox_pkg::ROW_W'(rgbbox_pkg::ROW_LIMIT))) begin
      row_d = row_q + rgbbox_pkg::ROW_W'(1);
    end
    cnt_d = s1_d.emit ? cnt_inc : cnt_q;
    if (s1_d.last) begin
      col_d = '0;
      row_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store data arrives, window shifts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q      <= s1_d;
      byp_up_q  <= mid_raw;
      byp_mid_q <= s1_q.pix;
    end
  end

  rgbbox_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.addr),
    .wdata_i (mid_raw),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  rgbbox_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.addr),
    .wdata_i (s1_q.pix),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  assign up_raw  = s1_q.byp ? byp_up_q  : up_rd;
  assign mid_raw = s1_q.byp ? byp_mid_q : mid_rd;

  // rows above or below the image read as zero
  assign new_col.top = s1_q.top_ok ? up_raw  : '0;
  assign new_col.mid = s1_q.mid_ok ? mid_raw : '0;
  assign new_col.bot = s1_q.pix;

  assign win_ctrl.shift     = s1_adv;
  assign win_ctrl.col_start = s1_q.col_start;
  assign win_ctrl.clear     = cfg_wr;

  rgbbox_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .col_i  (new_col),
    .sums_o (sums)
  );

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      res_sums_q <= sums;
      res_last_q <= s1_q.last;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign red_sum_o    = res_sums_q[rgbbox_pkg::CH_RED];
  assign green_sum_o  = res_sums_q[rgbbox_pkg::CH_GRN];
  assign blue_sum_o   = res_sums_q[rgbbox_pkg::CH_BLU];
  assign last_pixel_o = res_last_q;

  // ---------------------------------------------------------------------------
  // Assertions

  // the column position never reaches the row width
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(w_eff))
    else $error("column position beyond image width");

  // the item closing an image has already restarted the position
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.last |-> (col_q == '0) && (row_q == '0) && (cnt_q == '0))
    else $error("position not restarted after last pixel");

  // input stalls only behind a waiting result and a result-giving item
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_q.emit && out_valid_o && !out_ready_i)
    else $error("input stalled without cause");

  // weighted sums stay within ten times a full-scale channel
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(red_sum_o) <= rgbbox_pkg::SUM_MAX)
                 && (32'(green_sum_o) <= rgbbox_pkg::SUM_MAX)
                 && (32'(blue_sum_o) <= rgbbox_pkg::SUM_MAX))
    else $error("weighted sum out of range");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for rgb_3x3_weighted_box_filter: directed and random pixel streams
// checked against a cycle-free model of the weighted 3x3 sums and the last_pixel flag.
// Depends on rgbbox_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_RAND_ITEMS = 1600;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES   = 6;

  typedef enum int {
    IDLE_RX_MORE,  // sender 37 %, receiver 47 %
    IDLE_TX_MORE,  // sender 47 %, receiver 37 %
    IDLE_OFF
  } idle_mode_e;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic [rgbbox_pkg::SUM_W-1:0] red;
    logic [rgbbox_pkg::SUM_W-1:0] green;
    logic [rgbbox_pkg::SUM_W-1:0] blue;
    logic                         last;
  } filt_res_t;

  // DUT ports
  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             psel         = 1'b0;
  logic                             penable      = 1'b0;
  logic                             pwrite       = 1'b0;
  logic [rgbbox_pkg::PADDR_W-1:0]   paddr        = '0;
  logic [rgbbox_pkg::PDATA_W-1:0]   pwdata       = '0;
  logic [rgbbox_pkg::PDATA_W-1:0]   prdata;
  logic                             pready;
  logic                             in_valid_i   = 1'b0;
  logic                             in_ready_o;
  logic                             func_i       = 1'b0;
  logic [rgbbox_pkg::CH_W-1:0]      red_i        = '0;
  logic [rgbbox_pkg::CH_W-1:0]      green_i      = '0;
  logic [rgbbox_pkg::CH_W-1:0]      blue_i       = '0;
  logic                             out_valid_o;
  logic                             out_ready_i  = 1'b0;
  logic [rgbbox_pkg::SUM_W-1:0]     red_sum_o;
  logic [rgbbox_pkg::SUM_W-1:0]     green_sum_o;
  logic [rgbbox_pkg::SUM_W-1:0]     blue_sum_o;
  logic                             last_pixel_o;

  // Stimulus and scoreboard
  pixel_item_t  pixel_q[$];
  filt_res_t    pending_sums[$];
  idle_mode_e   idle_mode = IDLE_RX_MORE;
  int unsigned  err_count = 0;
  int unsigned  stall_count = 0;
  pixel_item_t  next_pix;
  filt_res_t    got_res;
  filt_res_t    want_res;

  // Model state
  logic [23:0]                     upper_mem [rgbbox_pkg::MAX_WIDTH_DEF];
  logic [23:0]                     middle_mem [rgbbox_pkg::MAX_WIDTH_DEF];
  logic [23:0]                     win [9];  // index col*3+row, col 0 left, row 0 top
  int unsigned                     col_pos;
  int unsigned                     row_pos;
  logic [rgbbox_pkg::CNT_W-1:0]    res_count;
  logic [rgbbox_pkg::WREG_W-1:0]   width_reg;
  logic [rgbbox_pkg::HREG_W-1:0]   height_reg;

  rgb_3x3_weighted_box_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_sum_o    (red_sum_o),
    .green_sum_o  (green_sum_o),
    .blue_sum_o   (blue_sum_o),
    .last_pixel_o (last_pixel_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > rgbbox_pkg::MAX_WIDTH_DEF) return rgbbox_pkg::MAX_WIDTH_DEF;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > rgbbox_pkg::MAX_HEIGHT) return rgbbox_pkg::MAX_HEIGHT;
    return 32'(height_reg);
  endfunction

  function automatic int unsigned tx_idle_pct();
    case (idle_mode)
      IDLE_RX_MORE: return 37;
      IDLE_TX_MORE: return 47;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct();
    case (idle_mode)
      IDLE_RX_MORE: return 47;
      IDLE_TX_MORE: return 37;
      default: return 0;
    endcase
  endfunction

  // Weighted sum of one channel: centre counts twice
  function automatic logic [rgbbox_pkg::SUM_W-1:0] chan_sum(input int sh);
    logic [rgbbox_pkg::SUM_W-1:0] s;
    logic [7:0]                   c;
    s = '0;
    for (int k = 0; k < 9; k++) begin
      c = win[k][sh +: 8];
      s = s + {4'd0, c} + ((k == 4) ? {4'd0, c} : 12'd0);
    end
    return s;
  endfunction

  task automatic restart_stream();
    col_pos   = 0;
    row_pos   = 0;
    res_count = '0;
    for (int k = 0; k < 9; k++) win[k] = '0;
  endtask

  // Advance the model by one accepted item, queue the sums it gives
  task automatic box_sum_step(input logic f, input logic [7:0] r, g, b);
    int unsigned w, h, ir, ic;
    logic [23:0] v, up, md, top, midv;
    logic        emit;
    filt_res_t   res;
    w  = eff_w();
    h  = eff_h();
    ir = row_pos;
    ic = col_pos;
    if (ic >= w) ic = 0;
    v = (!f && ir < h) ? {r, g, b} : 24'd0;
    up = upper_mem[ic];
    md = middle_mem[ic];
    upper_mem[ic]  = md;
    middle_mem[ic] = v;
    // rows outside the image read as zero
    top  = (ir >= 2 && ir - 2 < h) ? up : 24'd0;
    midv = (ir >= 1 && ir - 1 < h) ? md : 24'd0;
    emit = (ir >= 2) || (ir == 1 && ic >= 1);
    for (int k = 0; k < 6; k++) win[k] = win[k + 3];
    if (ic == 0) begin
      // right edge of the previous row is zero
      win[6] = '0;
      win[7] = '0;
      win[8] = '0;
    end else begin
      win[6] = top;
      win[7] = midv;
      win[8] = v;
    end
    res = '0;
    if (emit) begin
      res.red   = chan_sum(16);
      res.green = chan_sum(8);
      res.blue  = chan_sum(0);
    end
    if (ic == 0) begin
      for (int k = 0; k < 6; k++) win[k] = '0;
      win[6] = top;
      win[7] = midv;
      win[8] = v;
    end
    ic++;
    if (ic >= w) begin
      ic = 0;
      if (ir < rgbbox_pkg::ROW_LIMIT) ir++;
    end
    col_pos = ic;
    row_pos = ir;
    if (emit) begin
      res_count = res_count + 1'b1;
      res.last  = ({9'd0, res_count} == w * h);
      if (res.last) restart_stream();
      pending_sums.push_back(res);
    end
  endtask

  task automatic push_pixel(input logic f, input logic [7:0] r, g, b);
    pixel_q.push_back('{func: f, red: r, green: g, blue: b});
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // One image in raster order plus the W + 1 padding items that drain it;
  // a cut image stops at a random point before its last result
  task automatic queue_image(input bit cut, output int unsigned n);
    int unsigned w, h, total, stop;
    w     = eff_w();
    h     = eff_h();
    total = w * h + w + 1;
    stop  = cut ? $urandom_range(1, total - 1) : total;
    for (int unsigned k = 0; k < stop; k++) begin
      if (k < w * h) push_pixel($urandom_range(0, 15) == 0, rnd8(), rnd8(), rnd8());
      else push_pixel(1'($urandom_range(0, 1)), rnd8(), rnd8(), rnd8());
    end
    n = stop;
  endtask

  // Wait until all items are in, all sums are out and the pipeline is empty
  task automatic wait_drain();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || pending_sums.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_read_check(input rgbbox_pkg::cfg_reg_e idx,
                                input logic [rgbbox_pkg::PDATA_W-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== want) report_mismatch(idx.name(), prdata, want);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Register write with junk in the unused upper bits, then read back
  task automatic cfg_write(input rgbbox_pkg::cfg_reg_e idx, input int unsigned val);
    logic [rgbbox_pkg::PDATA_W-1:0] word;
    word = $urandom();
    if (idx == rgbbox_pkg::REG_IMAGE_WIDTH) begin
      word[rgbbox_pkg::WREG_W-1:0] = val[rgbbox_pkg::WREG_W-1:0];
    end else begin
      word[rgbbox_pkg::HREG_W-1:0] = val[rgbbox_pkg::HREG_W-1:0];
    end
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rgbbox_pkg::REG_IMAGE_WIDTH) width_reg = val[rgbbox_pkg::WREG_W-1:0];
    else height_reg = val[rgbbox_pkg::HREG_W-1:0];
    restart_stream();
    cfg_read_check(idx, (idx == rgbbox_pkg::REG_IMAGE_WIDTH) ?
                        rgbbox_pkg::PDATA_W'(width_reg) :
                        rgbbox_pkg::PDATA_W'(height_reg));
  endtask

  // Driver: present queued items, hold each until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) box_sum_step(func_i, red_i, green_i, blue_i);
      if (!in_valid_i || in_ready_o) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
          next_pix   = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= next_pix.func;
          red_i      <= next_pix.red;
          green_i    <= next_pix.green;
          blue_i     <= next_pix.blue;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct());
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res = '{red: red_sum_o, green: green_sum_o, blue: blue_sum_o, last: last_pixel_o};
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want_res = pending_sums.pop_front();
        if (got_res.red !== want_res.red)
          report_mismatch("red_sum", got_res.red, want_res.red);
        if (got_res.green !== want_res.green)
          report_mismatch("green_sum", got_res.green, want_res.green);
        if (got_res.blue !== want_res.blue)
          report_mismatch("blue_sum", got_res.blue, want_res.blue);
        if (got_res.last !== want_res.last)
          report_mismatch("last_pixel", got_res.last, want_res.last);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Sequence
  initial begin
    int unsigned n, rand_cnt, n_img, w_raw, h_raw;
    bit          force_pause;

    width_reg  = rgbbox_pkg::WREG_W'(rgbbox_pkg::WIDTH_RST);
    height_reg = rgbbox_pkg::HREG_W'(rgbbox_pkg::HEIGHT_RST);
    for (int k = 0; k < rgbbox_pkg::MAX_WIDTH_DEF; k++) begin
      upper_mem[k]  = '0;
      middle_mem[k] = '0;
    end
    restart_stream();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset values of the size registers
    cfg_read_check(rgbbox_pkg::REG_IMAGE_WIDTH,
                   rgbbox_pkg::PDATA_W'(rgbbox_pkg::WIDTH_RST));
    cfg_read_check(rgbbox_pkg::REG_IMAGE_HEIGHT,
                   rgbbox_pkg::PDATA_W'(rgbbox_pkg::HEIGHT_RST));

    // Directed: saturated 3x3 image, centre gives the largest sum;
    // a data pixel past the last row must be ignored
    cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, 3);
    cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, 3);
    repeat (9) push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(1'b0, 8'd77, 8'd88, 8'd99);
    repeat (3) push_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
    wait_drain();

    // Zero sizes fall back to a 1x1 image
    cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, 0);
    cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, 0);
    push_pixel(1'b0, 8'h80, 8'h01, 8'hFE);
    push_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    push_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    wait_drain();

    // Flush inside the image acts as a zero pixel
    cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, 2);
    cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, 2);
    push_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    push_pixel(1'b0, 8'h01, 8'h02, 8'h04);
    push_pixel(1'b0, 8'hFF, 8'h80, 8'h40);
    repeat (3) push_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    wait_drain();

    // Out-of-range sizes are clamped; a short stretch of the first row
    // runs under them
    cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, 8191);
    cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, 4095);
    repeat (24) push_pixel(1'b0, rnd8(), rnd8(), rnd8());
    wait_drain();

    // Random images of mostly small sizes, some cut short
    rand_cnt    = 0;
    force_pause = 1'b1;
    while (rand_cnt < NUM_RAND_ITEMS) begin
      if (rand_cnt < NUM_RAND_ITEMS / 3) idle_mode = IDLE_RX_MORE;
      else if (rand_cnt < 2 * NUM_RAND_ITEMS / 3) idle_mode = IDLE_TX_MORE;
      else idle_mode = IDLE_OFF;
      case ($urandom_range(0, 9))
        0: w_raw = 0;
        1: w_raw = $urandom_range(9, 40);
        default: w_raw = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: h_raw = 0;
        1: h_raw = $urandom_range(7, 12);
        default: h_raw = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 1)) begin
        cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, w_raw);
        cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, h_raw);
      end else begin
        cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, h_raw);
        cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, w_raw);
      end
      n_img = force_pause ? 2 : $urandom_range(1, 3);
      for (int unsigned i = 0; i < n_img; i++) begin
        // sender holds off until every pending sum has come back
        if (i > 0 && (force_pause || $urandom_range(0, 3) == 0)) begin
          force_pause = 1'b0;
          @(negedge clk_i);
          while (pixel_q.size() != 0 || in_valid_i || pending_sums.size() != 0)
            @(negedge clk_i);
        end
        queue_image(i == n_img - 1 && $urandom_range(0, 4) == 0, n);
        rand_cnt += n;
      end
      wait_drain();
    end

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
